@@ hdl/bds_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bds_pkg
// Shared types, register codes and pixel packing for the 2x2 box downsampler.
// ---------------------------------------------------------------------------
package bds_pkg;

  localparam int DEFAULT_MAX_WIDTH = 2048;

  localparam int DIM_W  = 12;  // width/height register bits
  localparam int BPP_W  = 3;
  localparam int FMT_W  = 2;
  localparam int PIX_W  = 32;
  localparam int LANES  = 4;
  localparam int PAIR_W = 9;   // sum of two bytes
  localparam int PS_W   = LANES * PAIR_W;
  localparam int IDX_W  = 3;   // config register index bits
  localparam int CFG_W  = 12;  // config write data bits

  // config register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BPP        = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_FMT    = 3'd3;

  // output formats
  localparam logic [FMT_W-1:0] FMT_RAW  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_4444 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_5551 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_565  = 2'd3;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd16;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd16;
  localparam logic [BPP_W-1:0] RST_BPP    = 3'd4;
  localparam logic [FMT_W-1:0] RST_FMT    = FMT_RAW;

  localparam logic [7:0] NIBBLE_MASK = 8'hF0;

  typedef logic [LANES-1:0][7:0] lane_bytes_t;

  function automatic logic [PIX_W-1:0] pack_pixel(input lane_bytes_t b,
                                                  input logic [FMT_W-1:0] fmt);
    logic [15:0] p;
    p = 16'd0;
    case (fmt)
      FMT_4444: begin
        p = {(b[0] & NIBBLE_MASK) | {4'd0, b[1][7:4]},
             (b[2] & NIBBLE_MASK) | {4'd0, b[3][7:4]}};
        pack_pixel = {16'd0, p};
      end
      FMT_5551: begin
        p = {b[0][7:3], b[1][7:3], b[2][7:3], b[3][7]};
        pack_pixel = {16'd0, p};
      end
      FMT_565: begin
        p = {b[0][7:3], b[1][7:2], b[2][7:3]};
        pack_pixel = {16'd0, p};
      end
      default: begin
        pack_pixel = {b[3], b[2], b[1], b[0]};
      end
    endcase
  endfunction

endpackage

@@ hdl/box_downsample_2x2_pack_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_downsample_2x2_pack_top
// 2x2 box-filter downsampler with raw or 16-bit packed output.
// ---------------------------------------------------------------------------
// Source pixels stream in raster order, one item per clock when both sides
// keep up; for every 2x2 block, the bottom-right source pixel reads the
// upper-row pair sums from the pair-sum line memory into stage 1, and the
// averaged pixel is then registered in the output register with dest_valid.
// Throughput is one source item per cycle while the destination keeps up;
// the single-port line memory is written in even source rows and read in
// odd rows, never both for one item. The source side stalls only while
// stage 1 holds a result and the output register is full with dest_ready
// low. The line
// memory holds MAX_WIDTH/2 entries of four 9-bit pair sums; it needs no clear
// after reset, since every entry is written in an upper row before the row
// below reads it. A bad frame setup (size below 2, width above MAX_WIDTH,
// bytes_per_pixel outside 1..4, or a packed format that does not match the
// byte count) gives one error item at the start of each frame. Odd trailing
// columns and rows are consumed and dropped. Writes to config indexes 0..3
// restart the frame; config writes must only be made while the block is idle.
// ---------------------------------------------------------------------------
module box_downsample_2x2_pack_top
  import bds_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // source stream
  input  logic                src_valid,
  output logic                src_ready,
  input  logic [PIX_W-1:0]    src_pixel,
  // destination stream
  output logic                dest_valid,
  input  logic                dest_ready,
  output logic [PIX_W-1:0]    dest_pixel,
  output logic                last_pixel,
  output logic                error
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // config registers
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [BPP_W-1:0] bytes_per_pixel;
  logic [FMT_W-1:0] output_format;

  // raster position of the next source item
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [PIX_W-1:0] left_pixel_hold;

  // line memory of upper-row pair sums
  logic [PS_W-1:0]  pair_sum_line [LINE_DEPTH];
  logic [PS_W-1:0]  line_rd_data;

  // stage 1: waiting for line memory data
  logic             s1_valid;
  logic             s1_err;
  logic             s1_last;
  logic [PS_W-1:0]  s1_ps;

  // ---- frame setup check ----
  logic frame_err;
  always_comb begin
    frame_err = 1'b0;
    if (src_width < 12'd2 || src_height < 12'd2 ||
        {20'd0, src_width} > 32'(MAX_WIDTH))
      frame_err = 1'b1;
    if (bytes_per_pixel < 3'd1 || bytes_per_pixel > 3'd4)
      frame_err = 1'b1;
    if ((output_format == FMT_4444 || output_format == FMT_5551) &&
        bytes_per_pixel != 3'd4)
      frame_err = 1'b1;
    if (output_format == FMT_565 && bytes_per_pixel != 3'd3)
      frame_err = 1'b1;
  end

  // ---- handshake ----
  logic s1_adv;
  logic src_acc;
  assign s1_adv    = !dest_valid || dest_ready;
  assign src_ready = !s1_valid || s1_adv;
  assign src_acc   = src_valid && src_ready;

  // ---- raster counters ----
  logic [DIM_W-1:0] eff_w, eff_h;     // zero counts as one
  logic [DIM_W:0]   col_inc, row_inc;
  logic [DIM_W-1:0] col_next, row_next;
  logic [DIM_W-1:0] even_w, even_h;

  always_comb begin
    eff_w   = (src_width == '0) ? 12'd1 : src_width;
    eff_h   = (src_height == '0) ? 12'd1 : src_height;
    col_inc = {1'b0, column_count} + 13'd1;
    row_inc = {1'b0, row_count} + 13'd1;
    if (col_inc >= {1'b0, eff_w}) begin
      col_next = '0;
      row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_next = col_inc[DIM_W-1:0];
      row_next = row_count;
    end
    even_w = {src_width[DIM_W-1:1], 1'b0};
    even_h = {src_height[DIM_W-1:1], 1'b0};
  end

  // ---- item decode ----
  logic            in_block;
  logic            odd_col;
  logic            lower_row;
  logic            idx_ok;
  logic            is_last;
  logic [31:0]     idx_wide;
  logic [ADDR_W-1:0] line_addr;
  logic [PS_W-1:0] ps;
  logic            err_item;
  logic            line_wr;
  logic            line_rd;
  logic            hold_load;

  always_comb begin
    in_block  = (column_count < even_w) && (row_count < even_h);
    odd_col   = column_count[0];
    lower_row = row_count[0];
    idx_wide  = {21'd0, column_count[DIM_W-1:1]};
    idx_ok    = idx_wide < 32'(LINE_DEPTH);
    line_addr = idx_wide[ADDR_W-1:0];
    is_last   = (column_count == even_w - 12'd1) && (row_count == even_h - 12'd1);

    // horizontal pair sums, unused lanes zero
    ps = '0;
    for (int k = 0; k < LANES; k++) begin
      if (3'(k) < bytes_per_pixel)
        ps[k*PAIR_W +: PAIR_W] = {1'b0, left_pixel_hold[k*8 +: 8]} +
                                 {1'b0, src_pixel[k*8 +: 8]};
    end

    err_item  = src_acc && frame_err && column_count == '0 && row_count == '0;
    hold_load = src_acc && !frame_err && in_block && !odd_col;
    line_wr   = src_acc && !frame_err && in_block && odd_col && idx_ok && !lower_row;
    line_rd   = src_acc && !frame_err && in_block && odd_col && idx_ok && lower_row;
  end

  // ---- line memory ----
  always_ff @(posedge clk) begin
    if (line_wr)
      pair_sum_line[line_addr] <= ps;
    if (line_rd)
      line_rd_data <= pair_sum_line[line_addr];
  end

  // ---- stage 1 combine and pack ----
  lane_bytes_t     avg;
  logic [PIX_W-1:0] dest_next;
  logic [9:0]      lane_sum;

  always_comb begin
    avg      = '0;
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      lane_sum = {1'b0, line_rd_data[k*PAIR_W +: PAIR_W]} +
                 {1'b0, s1_ps[k*PAIR_W +: PAIR_W]};
      if (3'(k) < bytes_per_pixel)
        avg[k] = lane_sum[9:2];
    end
    dest_next = s1_err ? '0 : pack_pixel(avg, output_format);
  end

  // ---- control and config registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= RST_WIDTH;
      src_height      <= RST_HEIGHT;
      bytes_per_pixel <= RST_BPP;
      output_format   <= RST_FMT;
      column_count    <= '0;
      row_count       <= '0;
      left_pixel_hold <= '0;
      s1_valid        <= 1'b0;
      dest_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH: begin
            src_width    <= cfg_data[DIM_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          REG_SRC_HEIGHT: begin
            src_height   <= cfg_data[DIM_W-1:0];
            column_count <= '0;
            row_count    <= '0;
          end
          REG_BPP: begin
            bytes_per_pixel <= cfg_data[BPP_W-1:0];
            column_count    <= '0;
            row_count       <= '0;
          end
          REG_OUT_FMT: begin
            output_format <= cfg_data[FMT_W-1:0];
            column_count  <= '0;
            row_count     <= '0;
          end
          default: begin
          end
        endcase
      end else if (src_acc) begin
        column_count <= col_next;
        row_count    <= row_next;
      end

      if (hold_load)
        left_pixel_hold <= src_pixel;

      if (err_item || line_rd)
        s1_valid <= 1'b1;
      else if (s1_adv)
        s1_valid <= 1'b0;

      if (s1_valid && s1_adv)
        dest_valid <= 1'b1;
      else if (dest_ready)
        dest_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (err_item || line_rd) begin
      s1_err  <= err_item;
      s1_last <= err_item || is_last;
      s1_ps   <= ps;
    end
    if (s1_valid && s1_adv) begin
      dest_pixel <= dest_next;
      last_pixel <= s1_last;
      error      <= s1_err;
    end
  end

  // ---- assertions ----
  a_err_item_form: assert property (@(posedge clk) disable iff (rst)
    dest_valid && error |-> last_pixel && dest_pixel == '0)
    else $error("error item without last flag or with nonzero pixel");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    line_rd |=> s1_valid && !s1_err)
    else $error("line read without a pending stage 1 item");

  a_packed_upper_zero: assert property (@(posedge clk) disable iff (rst)
    dest_valid && output_format != FMT_RAW |-> dest_pixel[31:16] == 16'd0)
    else $error("packed pixel has upper half set");

  a_no_rw_same_item: assert property (@(posedge clk) disable iff (rst)
    !(line_wr && line_rd))
    else $error("line memory read and write for one item");

  a_reset_counters: assert property (@(posedge clk)
    !rst && $past(rst) |-> column_count == '0 && row_count == '0 && !dest_valid)
    else $error("counters not cleared by reset");

endmodule

@@ dv/box_downsample_2x2_pack_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_downsample_2x2_pack_top_test
// Self-checking bench for the 2x2 box downsampler with 16-bit packing.
// ---------------------------------------------------------------------------
// Source pixels are queued by the stimulus process and presented by a
// valid/ready driver with random gaps. The destination side stalls at random.
// Every accepted source item runs through a bench-side downsampler (line of
// upper-row pair sums, raster counters, packing) that queues the result it
// should cause; each accepted destination item is checked against the oldest
// queued result. Setup changes are made only with the block drained.
// ---------------------------------------------------------------------------
module box_downsample_2x2_pack_top_test;
  import bds_pkg::*;

  localparam int LINE_ENTRIES = DEFAULT_MAX_WIDTH / 2;
  localparam int DRAIN_CYCLES = 8;        // stage 1 and output register plus margin
  localparam int END_WAIT_CYCLES = 4000;  // bound on the final drain
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_ITEMS = 900;
  localparam int TIMEOUT_NS = 10_000_000;
  localparam int GAP_MAX = 19;
  localparam logic [IDX_W-1:0] REG_FIRST_UNUSED = REG_OUT_FMT + 1'b1;
  localparam logic [IDX_W-1:0] REG_LAST_UNUSED = '1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             err;
  } dest_item_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             src_valid = 1'b0;
  logic             src_ready;
  logic [PIX_W-1:0] src_pixel = '0;
  logic             dest_valid;
  logic             dest_ready = 1'b0;
  logic [PIX_W-1:0] dest_pixel;
  logic             last_pixel;
  logic             error;

  box_downsample_2x2_pack_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_pixel  (src_pixel),
    .dest_valid (dest_valid),
    .dest_ready (dest_ready),
    .dest_pixel (dest_pixel),
    .last_pixel (last_pixel),
    .error      (error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---- bench copy of the block's setup and state ----
  logic [DIM_W-1:0] set_width = RST_WIDTH;
  logic [DIM_W-1:0] set_height = RST_HEIGHT;
  logic [BPP_W-1:0] set_bpp = RST_BPP;
  logic [FMT_W-1:0] set_fmt = RST_FMT;
  logic [PS_W-1:0]  upper_pair_sums [0:LINE_ENTRIES-1];
  logic [PIX_W-1:0] left_px = '0;
  int unsigned      col_at = 0;
  int unsigned      row_at = 0;

  logic [PIX_W-1:0] src_pixel_q [$];   // pixels still to be presented
  dest_item_t       pending_dest_q [$]; // results owed by the block
  int               pushed_items = 0;
  int               accepted_items = 0;
  int               mismatches = 0;

  // handshake flags, sampled at the rising edge and used at the falling edge
  bit src_taken = 1'b0;
  bit dst_taken = 1'b0;
  int src_wait = 0;
  int dst_wait = 0;
  int src_gap_max = GAP_MAX;
  int dst_gap_max = GAP_MAX;

  function automatic bit frame_is_bad();
    if (set_width <= 1 || set_height <= 1 || set_width > DEFAULT_MAX_WIDTH) return 1'b1;
    if (set_bpp < 1 || set_bpp > LANES) return 1'b1;
    if ((set_fmt == FMT_4444 || set_fmt == FMT_5551) && set_bpp != 4) return 1'b1;
    if (set_fmt == FMT_565 && set_bpp != 3) return 1'b1;
    return 1'b0;
  endfunction

  // One accepted source pixel: advance the raster, keep pair sums of the upper
  // row, and on the bottom-right pixel of a block queue the averaged pixel.
  function automatic void downsample_pixel(input logic [PIX_W-1:0] px);
    int unsigned        c, r, cw, ch, dw, dh, idx;
    logic [PS_W-1:0]    ps;
    logic [PAIR_W-1:0]  up, lo;
    logic [PAIR_W:0]    sum4;
    lane_bytes_t        avg;
    dest_item_t         res;
    c = col_at;
    r = row_at;
    cw = (set_width == 0) ? 1 : set_width;
    ch = (set_height == 0) ? 1 : set_height;
    dw = set_width >> 1;
    dh = set_height >> 1;
    if (c + 1 >= cw) begin
      col_at = 0;
      row_at = (r + 1 >= ch) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end

    // bad setup: one error item at the top-left pixel of each frame
    if (frame_is_bad()) begin
      if (c == 0 && r == 0) begin
        res.pixel = '0;
        res.last = 1'b1;
        res.err = 1'b1;
        pending_dest_q.push_back(res);
      end
      return;
    end

    // trailing odd column or row is consumed without output
    if (c >= 2 * dw || r >= 2 * dh) return;

    if (c % 2 == 0) begin
      left_px = px;
      return;
    end

    idx = c / 2;
    ps = '0;
    for (int k = 0; k < LANES; k++) begin
      if (k < set_bpp)
        ps[PAIR_W*k +: PAIR_W] = PAIR_W'(left_px[8*k +: 8]) + PAIR_W'(px[8*k +: 8]);
    end
    if (r % 2 == 0) begin
      upper_pair_sums[idx] = ps;
      return;
    end

    for (int k = 0; k < LANES; k++) begin
      up = upper_pair_sums[idx][PAIR_W*k +: PAIR_W];
      lo = ps[PAIR_W*k +: PAIR_W];
      sum4 = {1'b0, up} + {1'b0, lo};
      avg[k] = (k < set_bpp) ? sum4[PAIR_W:2] : 8'd0;
    end
    case (set_fmt)
      FMT_4444: res.pixel = {16'd0, avg[0][7:4], avg[1][7:4], avg[2][7:4], avg[3][7:4]};
      FMT_5551: res.pixel = {16'd0, avg[0][7:3], avg[1][7:3], avg[2][7:3], avg[3][7]};
      FMT_565:  res.pixel = {16'd0, avg[0][7:3], avg[1][7:2], avg[2][7:3]};
      default:  res.pixel = avg;
    endcase
    res.last = (c == 2 * dw - 1 && r == 2 * dh - 1);
    res.err = 1'b0;
    pending_dest_q.push_back(res);
  endfunction

  // ---- monitor: both handshakes seen at the rising edge ----
  always @(posedge clk) begin
    dest_item_t want;
    src_taken = !rst && src_valid && src_ready;
    dst_taken = !rst && dest_valid && dest_ready;
    // check first, so an item accepted now cannot satisfy its own result
    if (dst_taken) begin
      if (pending_dest_q.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("%0t: dest item with none owed: pixel %08h last %b error %b",
                   $realtime, dest_pixel, last_pixel, error);
        mismatches++;
      end else begin
        want = pending_dest_q.pop_front();
        if (dest_pixel !== want.pixel || last_pixel !== want.last || error !== want.err) begin
          if (mismatches < MAX_SHOWN)
            $display("%0t: dest mismatch: pixel %08h/%08h last %b/%b error %b/%b (exp/got)",
                     $realtime, want.pixel, dest_pixel, want.last, last_pixel,
                     want.err, error);
          mismatches++;
        end
      end
    end
    if (src_taken) begin
      downsample_pixel(src_pixel);
      accepted_items++;
    end
  end

  // ---- source driver: pops the next pixel once the current one is taken ----
  always @(negedge clk) begin
    if (!rst) begin
      if (!src_valid || src_taken) begin
        if (src_wait > 0) begin
          src_valid <= 1'b0;
          src_wait--;
        end else if (src_pixel_q.size() > 0) begin
          src_valid <= 1'b1;
          src_pixel <= src_pixel_q.pop_front();
          src_wait = $urandom_range(0, src_gap_max);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // ---- destination side: stall a random count after each item ----
  always @(negedge clk) begin
    if (!rst) begin
      if (dst_taken) dst_wait = $urandom_range(0, dst_gap_max);
      if (dst_wait > 0) begin
        dest_ready <= 1'b0;
        dst_wait--;
      end else begin
        dest_ready <= 1'b1;
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: begin
        // lanes at 00 or FF, to hit the widest and narrowest sums
        for (int k = 0; k < LANES; k++) v[8*k +: 8] = {8{$urandom_range(0, 1) == 1}};
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] v);
    src_pixel_q.push_back(v);
    pushed_items++;
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_pixel(pick_pixel());
  endtask

  // all items taken, nothing owed, then let the pipe settle
  task automatic wait_idle();
    while (accepted_items != pushed_items || pending_dest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SRC_WIDTH:  set_width = data[DIM_W-1:0];
      REG_SRC_HEIGHT: set_height = data[DIM_W-1:0];
      REG_BPP:        set_bpp = data[BPP_W-1:0];
      REG_OUT_FMT:    set_fmt = data[FMT_W-1:0];
      default: ;
    endcase
    // a real register write restarts the frame; unused indexes do nothing
    if (idx <= REG_OUT_FMT) begin
      col_at = 0;
      row_at = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits of the narrow registers carry noise the block must ignore
  task automatic apply_setup(input int w, input int h, input int bpp,
                             input logic [FMT_W-1:0] fmt);
    logic [CFG_W-1:0] noise;
    noise = CFG_W'($urandom);
    write_reg(REG_SRC_WIDTH, CFG_W'(w));
    write_reg(REG_SRC_HEIGHT, CFG_W'(h));
    write_reg(REG_BPP, {noise[CFG_W-1:BPP_W], BPP_W'(bpp)});
    write_reg(REG_OUT_FMT, {noise[CFG_W-1:FMT_W], fmt});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin : stimulus
    int               random_items;
    int               n, w, h, bpp;
    logic [FMT_W-1:0] fmt;
    while (rst) @(negedge clk);

    // reset setup (16 wide, four lanes, raw): two rows give eight blocks
    push_random(32);
    wait_idle();

    // all-ones and all-zero blocks, second frame follows the first directly
    apply_setup(2, 2, 4, FMT_RAW);
    repeat (4) push_pixel('1);
    repeat (4) push_pixel('0);
    wait_idle();

    // each packed format on a single block
    apply_setup(2, 2, 4, FMT_4444);
    push_random(4);
    wait_idle();
    apply_setup(2, 2, 4, FMT_5551);
    push_random(4);
    wait_idle();
    apply_setup(2, 2, 3, FMT_565);
    push_random(4);
    wait_idle();

    // one lane only: upper lanes must read zero
    apply_setup(2, 2, 1, FMT_RAW);
    repeat (4) push_pixel('1);
    wait_idle();

    // width of one: a two-pixel frame with a single error item
    apply_setup(1, 2, 4, FMT_RAW);
    push_random(2);
    wait_idle();

    // zero size: every pixel is a frame of its own
    apply_setup(0, 0, 4, FMT_RAW);
    push_random(2);
    wait_idle();

    // unused register index mid-frame must not restart the frame
    apply_setup(4, 2, 2, FMT_RAW);
    push_random(3);
    wait_idle();
    write_reg(REG_LAST_UNUSED, CFG_W'($urandom));
    push_random(5);
    wait_idle();

    // widest legal width: no error item, the frame is only started
    apply_setup(DEFAULT_MAX_WIDTH, 2, 4, FMT_RAW);
    push_random(16);
    wait_idle();

    // two frames back to back at full source rate
    src_gap_max = 0;
    apply_setup(32, 4, 4, FMT_RAW);
    push_random(2 * 32 * 4);
    wait_idle();
    src_gap_max = GAP_MAX;

    // widest register value is an error; tallest is a legal (partial) frame
    apply_setup((1 << DIM_W) - 1, 2, 4, FMT_RAW);
    push_random(6);
    wait_idle();
    apply_setup(2, (1 << DIM_W) - 1, 3, FMT_565);
    push_random(8);
    wait_idle();

    // ---- random phases ----
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      dst_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      case ($urandom_range(0, 9))
        0: begin
          // keep going in the current frame after a full drain
          if ($urandom_range(0, 1) == 1)
            write_reg(IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CFG_W'($urandom));
          n = $urandom_range(1, 40);
        end
        1, 2: begin
          // bad setups
          w = $urandom_range(2, 9);
          h = $urandom_range(2, 5);
          fmt = FMT_RAW;
          bpp = $urandom_range(1, 4);
          case ($urandom_range(0, 4))
            0: w = $urandom_range(0, 1);
            1: h = $urandom_range(0, 1);
            2: w = $urandom_range(DEFAULT_MAX_WIDTH + 1, (1 << DIM_W) - 1);
            3: begin
              bpp = $urandom_range(5, 8) % 8;
              fmt = FMT_W'($urandom_range(FMT_RAW, FMT_565));
            end
            default: begin
              fmt = FMT_W'($urandom_range(FMT_4444, FMT_565));
              bpp = $urandom_range(1, 3);
              if (fmt == FMT_565 && bpp == 3) bpp = 4;
            end
          endcase
          apply_setup(w, h, bpp, fmt);
          n = $urandom_range(1, 24);
        end
        default: begin
          // well-formed frames with random content, sometimes cut short
          fmt = FMT_W'($urandom_range(FMT_RAW, FMT_565));
          bpp = (fmt == FMT_RAW) ? $urandom_range(1, 4) : (fmt == FMT_565) ? 3 : 4;
          w = $urandom_range(2, 13);
          h = $urandom_range(2, 7);
          apply_setup(w, h, bpp, fmt);
          n = w * h * $urandom_range(1, 2);
          if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
        end
      endcase
      push_random(n);
      random_items += n;
      wait_idle();
    end

    // final drain, bounded; anything still owed is a failure
    while (accepted_items != pushed_items) @(negedge clk);
    for (int i = 0; i < END_WAIT_CYCLES && pending_dest_q.size() != 0; i++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_dest_q.size() != 0) begin
      if (mismatches < MAX_SHOWN)
        $display("%0t: %0d dest items never arrived", $realtime, pending_dest_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
